// File: sv/utmc_pkg.sv
// Shared types and constants for the ultrasonic trigger mode controller.
`timescale 1ns / 1ps
`default_nettype none
package utmc_pkg;

	typedef enum logic [2:0] {
		MODE_STOP   = 3'd0,
		MODE_MANUAL = 3'd1,
		MODE_WAIT   = 3'd2,
		MODE_REC    = 3'd3,
		MODE_TEST   = 3'd4
	} mode_t;

	typedef enum logic [1:0] {
		REQ_HOST   = 2'd0,
		REQ_EDGE   = 2'd1,
		REQ_SAMPLE = 2'd2,
		REQ_TICK   = 2'd3
	} req_kind_t;

	typedef enum logic [2:0] {
		MSG_NONE      = 3'd0,
		MSG_REC_START = 3'd1,
		MSG_REC_STOP  = 3'd2,
		MSG_TH_ACK    = 3'd3,
		MSG_DIST      = 3'd4,
		MSG_AVG       = 3'd5
	} msg_t;

	localparam logic CMD_START = 1'b0;
	localparam logic CMD_STOP  = 1'b1;

	localparam logic [7:0] CH_MANUAL = 8'h4D; // 'M'
	localparam logic [7:0] CH_STOP   = 8'h53; // 'S'
	localparam logic [7:0] CH_WAIT   = 8'h44; // 'D'
	localparam logic [7:0] CH_TEST   = 8'h54; // 'T'
	localparam logic [7:0] CH_THRESH = 8'h52; // 'R'

	localparam logic [7:0] TH_MIN = 8'd2;
	localparam logic [7:0] TH_MAX = 8'd200;

	localparam logic [3:0] DEB_RESET = 4'd3;

	// near limit in echo units: width*343 < th*200000 + 20  <=>  dist <= th*10000
	localparam int unsigned LIM_W = 26;
	localparam logic [LIM_W-1:0] LIM_SCALE = 26'd200000;
	localparam logic [LIM_W-1:0] LIM_OFS   = 26'd20;
	localparam logic [LIM_W-1:0] LIM_RESET = 26'd2000020;

	localparam logic [40:0] SOUND_MUL = 41'd343;
	// floor(x/5) = (x * RECIP5) >> 34 for any 32-bit x
	localparam logic [31:0] RECIP5 = 32'hCCCCCCCD;

	typedef struct packed {
		req_kind_t   req_type;
		logic [7:0]  byte_value;
		logic [31:0] capture_time;
	} in_req_t;

	typedef struct packed {
		mode_t       mode;
		logic        cmd_valid;
		logic        cmd;
		msg_t        msg;
		logic        pulse;
		logic        led;
		logic [7:0]  th;
		logic [31:0] width;
	} res_t;

endpackage
`default_nettype wire

// File: sv/utmc_ctrl.sv
// Mode, debounce, edge pairing and sample window state; one request per cycle while fire is high.
`timescale 1ns / 1ps
`default_nettype none
module utmc_ctrl #(
	parameter int AVG_TAPS = 3
) (
	input  wire                          clk,
	input  wire                          arst_n,
	input  wire                          en,
	input  wire                          fire,
	input  utmc_pkg::in_req_t            req,
	input  wire  [3:0]                   deb_cnt,
	output utmc_pkg::res_t               res_s2,
	output logic [8+$clog2(AVG_TAPS)-1:0] sum_s2
);

	localparam int L      = $clog2(AVG_TAPS);
	localparam int SUM_W  = 8 + L;
	localparam int SLOT_W = (AVG_TAPS > 1) ? $clog2(AVG_TAPS) : 1;
	localparam logic [SLOT_W-1:0] SLOT_LAST = SLOT_W'(AVG_TAPS - 1);

	utmc_pkg::mode_t mode_q, mode_d;
	logic await_q, await_d;
	logic [utmc_pkg::LIM_W-1:0] lim_q, lim_d;
	logic fes_q, fes_d;
	logic [31:0] fet_q, fet_d;
	logic [3:0] near_q, near_d, far_q, far_d;
	logic [7:0] win_q [AVG_TAPS];
	logic [7:0] win_d [AVG_TAPS];
	logic [SLOT_W-1:0] slot_q, slot_d;
	logic led_q, led_d;

	utmc_pkg::res_t res;
	logic [SUM_W-1:0] sum;
	logic [31:0] width;
	logic [40:0] echo;
	logic near_hit, far_hit, ranging, win_wr;
	logic [3:0] near_inc, far_inc;
	logic [7:0] th;

	assign width    = req.capture_time - fet_q;
	assign echo     = {9'b0, width} * utmc_pkg::SOUND_MUL;
	assign near_hit = (width != 32'd0) && (echo < {15'b0, lim_q});
	assign far_hit  = !(echo < {15'b0, lim_q});
	assign near_inc = (near_q == 4'hF) ? near_q : near_q + 4'd1;
	assign far_inc  = (far_q == 4'hF) ? far_q : far_q + 4'd1;
	assign ranging  = (mode_q == utmc_pkg::MODE_WAIT) || (mode_q == utmc_pkg::MODE_REC) ||
		(mode_q == utmc_pkg::MODE_TEST);
	assign win_wr   = (req.req_type == utmc_pkg::REQ_SAMPLE) &&
		((mode_q == utmc_pkg::MODE_MANUAL) || (mode_q == utmc_pkg::MODE_REC));

	always_comb begin
		th = req.byte_value;
		if (req.byte_value < utmc_pkg::TH_MIN) begin
			th = utmc_pkg::TH_MIN;
		end else if (req.byte_value > utmc_pkg::TH_MAX) begin
			th = utmc_pkg::TH_MAX;
		end
	end

	// window with the new byte in place, and its sum
	always_comb begin
		sum = '0;
		for (int i = 0; i < AVG_TAPS; i++) begin
			win_d[i] = (win_wr && (slot_q == SLOT_W'(i))) ? req.byte_value : win_q[i];
			sum      = sum + SUM_W'(win_d[i]);
		end
	end

	always_comb begin
		mode_d  = mode_q;
		await_d = await_q;
		lim_d   = lim_q;
		fes_d   = fes_q;
		fet_d   = fet_q;
		near_d  = near_q;
		far_d   = far_q;
		slot_d  = slot_q;
		led_d   = led_q;

		res.cmd_valid = 1'b0;
		res.cmd       = utmc_pkg::CMD_START;
		res.msg       = utmc_pkg::MSG_NONE;
		res.pulse     = 1'b0;
		res.th        = th;
		res.width     = width;

		unique case (req.req_type)
			utmc_pkg::REQ_HOST: begin
				led_d = ~led_q;
				if (await_q) begin
					lim_d   = {18'b0, th} * utmc_pkg::LIM_SCALE + utmc_pkg::LIM_OFS;
					near_d  = 4'd0;
					far_d   = 4'd0;
					await_d = 1'b0;
					res.msg = utmc_pkg::MSG_TH_ACK;
				end else if (req.byte_value == utmc_pkg::CH_MANUAL) begin
					mode_d        = utmc_pkg::MODE_MANUAL;
					res.cmd_valid = 1'b1;
					res.cmd       = utmc_pkg::CMD_START;
				end else if (req.byte_value == utmc_pkg::CH_STOP) begin
					mode_d        = utmc_pkg::MODE_STOP;
					res.cmd_valid = 1'b1;
					res.cmd       = utmc_pkg::CMD_STOP;
				end else if (req.byte_value == utmc_pkg::CH_WAIT) begin
					mode_d = utmc_pkg::MODE_WAIT;
				end else if (req.byte_value == utmc_pkg::CH_TEST) begin
					mode_d = utmc_pkg::MODE_TEST;
				end else if (req.byte_value == utmc_pkg::CH_THRESH) begin
					await_d = 1'b1;
				end
			end
			utmc_pkg::REQ_EDGE: begin
				if (!ranging) begin
					fes_d = 1'b0;
				end else if (!fes_q) begin
					fet_d = req.capture_time;
					fes_d = 1'b1;
				end else begin
					fes_d = 1'b0;
					if (mode_q == utmc_pkg::MODE_TEST) begin
						res.msg = utmc_pkg::MSG_DIST;
					end else if (mode_q == utmc_pkg::MODE_WAIT) begin
						if (near_hit) begin
							far_d = 4'd0;
							if (near_inc >= deb_cnt) begin
								mode_d        = utmc_pkg::MODE_REC;
								near_d        = 4'd0;
								res.cmd_valid = 1'b1;
								res.cmd       = utmc_pkg::CMD_START;
								res.msg       = utmc_pkg::MSG_REC_START;
							end else begin
								near_d = near_inc;
							end
						end else begin
							near_d = 4'd0;
						end
					end else begin
						if (far_hit) begin
							near_d = 4'd0;
							if (far_inc >= deb_cnt) begin
								mode_d        = utmc_pkg::MODE_WAIT;
								far_d         = 4'd0;
								res.cmd_valid = 1'b1;
								res.cmd       = utmc_pkg::CMD_STOP;
								res.msg       = utmc_pkg::MSG_REC_STOP;
							end else begin
								far_d = far_inc;
							end
						end else begin
							far_d = 4'd0;
						end
					end
				end
			end
			utmc_pkg::REQ_SAMPLE: begin
				if (win_wr) begin
					slot_d  = (slot_q == SLOT_LAST) ? '0 : slot_q + SLOT_W'(1);
					res.msg = utmc_pkg::MSG_AVG;
				end
			end
			utmc_pkg::REQ_TICK: begin
				res.pulse = ranging;
			end
		endcase

		res.mode = mode_d;
		res.led  = led_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= utmc_pkg::MODE_STOP;
			await_q <= 1'b0;
			lim_q   <= utmc_pkg::LIM_RESET;
			fes_q   <= 1'b0;
			fet_q   <= '0;
			near_q  <= '0;
			far_q   <= '0;
			slot_q  <= '0;
			led_q   <= 1'b0;
			for (int i = 0; i < AVG_TAPS; i++) begin
				win_q[i] <= '0;
			end
		end else if (fire) begin
			mode_q  <= mode_d;
			await_q <= await_d;
			lim_q   <= lim_d;
			fes_q   <= fes_d;
			fet_q   <= fet_d;
			near_q  <= near_d;
			far_q   <= far_d;
			slot_q  <= slot_d;
			led_q   <= led_d;
			for (int i = 0; i < AVG_TAPS; i++) begin
				win_q[i] <= win_d[i];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			res_s2 <= res;
			sum_s2 <= sum;
		end
	end

endmodule
`default_nettype wire

// File: sv/utmc_post.sv
// Distance and average arithmetic stages and the result register.
`timescale 1ns / 1ps
`default_nettype none
module utmc_post #(
	parameter int AVG_TAPS = 3
) (
	input  wire                           clk,
	input  wire                           en,
	input  utmc_pkg::res_t                res_s2,
	input  wire  [8+$clog2(AVG_TAPS)-1:0] sum_s2,
	output utmc_pkg::res_t                res_q,
	output logic [31:0]                   host_value_q
);

	localparam int L      = $clog2(AVG_TAPS);
	localparam int SUM_W  = 8 + L;
	localparam int DIV_SH = SUM_W + L;
	localparam logic [DIV_SH:0] RECIP = (DIV_SH+1)'(((1 << DIV_SH) + AVG_TAPS - 1) / AVG_TAPS);
	localparam int PROD_W = SUM_W + DIV_SH + 1;

	// range = 17*w + floor(3*w/20) = floor(343*w/20)
	logic [33:0] three_w;
	logic [63:0] q_prod;
	logic [36:0] w17;
	logic [PROD_W-1:0] avg_prod;

	utmc_pkg::res_t res_s3;
	logic [36:0] w17_s3;
	logic [29:0] q_s3;
	logic [7:0]  avg_s3;

	logic [37:0] dist_full;
	logic [31:0] range_um;
	logic [31:0] value;

	assign three_w  = {2'b0, res_s2.width} + {1'b0, res_s2.width, 1'b0};
	assign q_prod   = {32'b0, three_w[33:2]} * {32'b0, utmc_pkg::RECIP5};
	assign w17      = {5'b0, res_s2.width} + {1'b0, res_s2.width, 4'b0};
	assign avg_prod = PROD_W'(sum_s2) * PROD_W'(RECIP);

	always_ff @(posedge clk) begin
		if (en) begin
			res_s3 <= res_s2;
			w17_s3 <= w17;
			q_s3   <= q_prod[63:34];
			avg_s3 <= avg_prod[DIV_SH +: 8];
		end
	end

	assign dist_full = {1'b0, w17_s3} + {8'b0, q_s3};
	assign range_um  = (|dist_full[37:32]) ? 32'hFFFF_FFFF : dist_full[31:0];

	always_comb begin
		unique case (res_s3.msg)
			utmc_pkg::MSG_TH_ACK: value = {24'b0, res_s3.th};
			utmc_pkg::MSG_DIST:   value = range_um;
			utmc_pkg::MSG_AVG:    value = {24'b0, avg_s3};
			default:              value = 32'd0;
		endcase
	end

	always_ff @(posedge clk) begin
		if (en) begin
			res_q        <= res_s3;
			host_value_q <= value;
		end
	end

endmodule
`default_nettype wire

// File: sv/ultrasonic_trigger_mode_controller_top.sv
// Top level of the ultrasonic trigger mode controller.
// Path: a request is registered in req_s1, res_s2, res_s3 and res_q before its result is valid.
// Throughput: one request per cycle; the four-stage pipeline freezes while a
// result waits under out_stall.
// Reset: arst_n clears all valids and returns the mode state to stop, the
// threshold to 10 cm and the debounce limit to 3; no clearing pass.
`timescale 1ns / 1ps
`default_nettype none
module ultrasonic_trigger_mode_controller_top #(
	parameter int AVG_TAPS = 3
) (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         in_valid,
	output logic        in_stall,
	input  wire  [1:0]  req_type,
	input  wire  [7:0]  byte_value,
	input  wire  [31:0] capture_time,
	output logic        out_valid,
	input  wire         out_stall,
	output logic [2:0]  mode,
	output logic        sampler_cmd_valid,
	output logic        sampler_cmd,
	output logic [2:0]  host_msg,
	output logic [31:0] host_value,
	output logic        trigger_pulse,
	output logic        led_on,
	input  wire         cfg_valid,
	output logic        cfg_ready,
	input  wire  [3:0]  deb_limit
);

	localparam int SUM_W = 8 + $clog2(AVG_TAPS);

	logic en;
	logic valid_s1, valid_s2, valid_s3, out_valid_q;
	logic [3:0] deb_q;
	utmc_pkg::in_req_t req_s1;
	utmc_pkg::res_t res_s2, res_q;
	logic [SUM_W-1:0] sum_s2;
	logic [31:0] host_value_q;

	assign en        = !(out_valid_q && out_stall);
	assign in_stall  = !en;
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			deb_q <= utmc_pkg::DEB_RESET;
		end else if (cfg_valid) begin
			deb_q <= deb_limit;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			valid_s2    <= 1'b0;
			valid_s3    <= 1'b0;
			out_valid_q <= 1'b0;
		end else if (en) begin
			valid_s1    <= in_valid;
			valid_s2    <= valid_s1;
			valid_s3    <= valid_s2;
			out_valid_q <= valid_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			req_s1.req_type     <= utmc_pkg::req_kind_t'(req_type);
			req_s1.byte_value   <= byte_value;
			req_s1.capture_time <= capture_time;
		end
	end

	utmc_ctrl #(
		.AVG_TAPS(AVG_TAPS)
	) u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (en),
		.fire   (valid_s1 && en),
		.req    (req_s1),
		.deb_cnt(deb_q),
		.res_s2 (res_s2),
		.sum_s2 (sum_s2)
	);

	utmc_post #(
		.AVG_TAPS(AVG_TAPS)
	) u_post (
		.clk         (clk),
		.en          (en),
		.res_s2      (res_s2),
		.sum_s2      (sum_s2),
		.res_q       (res_q),
		.host_value_q(host_value_q)
	);

	assign out_valid         = out_valid_q;
	assign mode              = res_q.mode;
	assign sampler_cmd_valid = res_q.cmd_valid;
	assign sampler_cmd       = res_q.cmd;
	assign host_msg          = res_q.msg;
	assign host_value        = host_value_q;
	assign trigger_pulse     = res_q.pulse;
	assign led_on            = res_q.led;

endmodule
`default_nettype wire
